### hw/rtl/id3r_pkg.sv
// ----------------------------------------------------------------------------
// id3r_pkg
// shared types, codes and constants of the id3v2 frame reader
// ----------------------------------------------------------------------------
package id3r_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int LEN_W        = 28;
    localparam int HC_W         = 4;

    localparam logic [1:0] PH_TAG     = 2'd0;
    localparam logic [1:0] PH_FRAME   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_PICTURE = 2'd2;
    localparam logic [1:0] KIND_NO_TAG  = 2'd3;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    localparam logic [7:0]  CHAR_LOW  = 8'd20;
    localparam logic [7:0]  CHAR_HIGH = 8'd126;
    localparam logic [7:0]  SIZE_MASK = 8'h7F;
    localparam logic [31:0] ID_APIC   = {8'h41, 8'h50, 8'h49, 8'h43};
    localparam logic [31:0] ID_TAG    = {8'h00, 8'h49, 8'h44, 8'h33};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        logic [1:0]       phase;
        logic [HC_W-1:0]  header_count;
        logic [LEN_W-1:0] tag_length;
        logic [LEN_W-1:0] byte_position;
        logic [31:0]      current_id;
        logic [LEN_W-1:0] frame_length;
        logic [LEN_W-1:0] payload_left;
        logic             frame_selected;
        logic             walk_mode;
    } walk_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        char_valid;
        logic [7:0]  char_value;
        logic [31:0] frame_name;
        logic        finished;
    } walk_result_t;

    localparam walk_state_t WALK_RESET = '{
        phase:          PH_TAG,
        header_count:   '0,
        tag_length:     '0,
        byte_position:  '0,
        current_id:     '0,
        frame_length:   '0,
        payload_left:   '0,
        frame_selected: 1'b0,
        walk_mode:      1'b0
    };

endpackage

### hw/rtl/id3r_step.sv
// ----------------------------------------------------------------------------
// id3r_step
// next-state and result logic for one file byte of the tag walk
// ----------------------------------------------------------------------------
module id3r_step
    import id3r_pkg::*;
(
    input  walk_state_t  cur,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    input  logic         mode,
    input  logic [31:0]  target_frame_id,
    output walk_state_t  nxt,
    output logic         res_valid,
    output walk_result_t res
);

    walk_state_t      s;
    logic [HC_W-1:0]  n;
    logic [LEN_W-1:0] pos_inc;
    logic [LEN_W-1:0] pl_dec;
    logic             tag_end;
    logic             fe_go;
    logic             fe_sel;
    logic             fe_cv;
    logic             shown;
    logic             printable;

    assign s         = first_byte ? WALK_RESET : cur;
    assign n         = s.header_count;
    assign pos_inc   = (s.byte_position != LEN_MAX) ? s.byte_position + 1'b1
                                                    : s.byte_position;
    assign pl_dec    = s.payload_left - 1'b1;
    assign tag_end   = pos_inc >= s.tag_length;
    assign printable = (data_byte >= CHAR_LOW) && (data_byte <= CHAR_HIGH);
    assign shown     = s.frame_selected && printable;

    always_comb
    begin
        nxt       = s;
        res_valid = 1'b0;
        res       = '0;
        fe_go     = 1'b0;
        fe_sel    = 1'b0;
        fe_cv     = 1'b0;

        case (s.phase)
            PH_TAG:
            begin
                if (n < HC_W'(3))
                    nxt.current_id = {8'h00, s.current_id[15:0], data_byte};
                if (n >= HC_W'(HEADER_BYTES - 4))
                    nxt.tag_length = {s.tag_length[LEN_W-8:0], data_byte[6:0]};
                if (n < HC_W'(HEADER_BYTES - 1))
                begin
                    nxt.header_count = n + 1'b1;
                end
                else
                begin
                    nxt.header_count = '0;
                    nxt.walk_mode    = mode;
                    if (s.current_id != ID_TAG)
                    begin
                        res_valid    = 1'b1;
                        res.kind     = KIND_NO_TAG;
                        res.finished = 1'b1;
                        nxt.phase    = PH_DONE;
                    end
                    else
                    begin
                        nxt.current_id = '0;
                        if (nxt.tag_length == '0)
                        begin
                            res_valid    = 1'b1;
                            res.kind     = KIND_END;
                            res.finished = 1'b1;
                            nxt.phase    = PH_DONE;
                        end
                        else
                        begin
                            nxt.phase = PH_FRAME;
                        end
                    end
                end
            end

            PH_FRAME:
            begin
                nxt.byte_position = pos_inc;
                if (n == '0 && data_byte == 8'h00)
                begin
                    res_valid    = 1'b1;
                    res.kind     = KIND_END;
                    res.finished = 1'b1;
                    nxt.phase    = PH_DONE;
                end
                else
                begin
                    if (n < HC_W'(4))
                        nxt.current_id = (n == '0) ? {24'h000000, data_byte}
                                                   : {s.current_id[23:0], data_byte};
                    else if (n < HC_W'(8))
                        nxt.frame_length = ((n == HC_W'(4)) ? '0
                                            : {s.frame_length[LEN_W-8:0], 7'h00})
                                           | LEN_W'(data_byte & SIZE_MASK);
                    if (n < HC_W'(HEADER_BYTES - 1))
                    begin
                        nxt.header_count = n + 1'b1;
                    end
                    else
                    begin
                        nxt.header_count   = '0;
                        nxt.frame_selected = s.walk_mode
                                             ? (s.current_id == target_frame_id)
                                             : (s.current_id != ID_APIC);
                        nxt.payload_left   = s.frame_length;
                        if (s.frame_length == '0)
                        begin
                            fe_go  = 1'b1;
                            fe_sel = nxt.frame_selected;
                        end
                        else
                        begin
                            nxt.phase = PH_PAYLOAD;
                        end
                    end
                end
            end

            PH_PAYLOAD:
            begin
                nxt.byte_position = pos_inc;
                nxt.payload_left  = pl_dec;
                if (pl_dec == '0)
                begin
                    fe_go  = 1'b1;
                    fe_sel = s.frame_selected;
                    fe_cv  = shown;
                end
                else if (shown)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_CHAR;
                    res.char_valid = 1'b1;
                    res.char_value = data_byte;
                    res.frame_name = s.current_id;
                end
            end

            default:
            begin
                nxt = s;
            end
        endcase

        // frame end: shared by empty frames and the last payload byte
        if (fe_go)
        begin
            nxt.phase        = PH_FRAME;
            nxt.header_count = '0;
            res.frame_name   = nxt.current_id;
            res.kind         = KIND_END;
            if (!s.walk_mode)
            begin
                res_valid      = 1'b1;
                res.kind       = (nxt.current_id == ID_APIC) ? KIND_PICTURE : KIND_END;
                res.char_valid = fe_cv;
                res.char_value = fe_cv ? data_byte : 8'h00;
                res.finished   = tag_end;
            end
            else if (fe_sel)
            begin
                res_valid      = 1'b1;
                res.char_valid = fe_cv;
                res.char_value = fe_cv ? data_byte : 8'h00;
                res.finished   = 1'b1;
            end
            else if (tag_end)
            begin
                res_valid    = 1'b1;
                res.finished = 1'b1;
            end
            if (res_valid && res.finished)
                nxt.phase = PH_DONE;
        end
    end

endmodule

### hw/rtl/id3v2_frame_reader.sv
// output: a result is registered and appears on the master side in the cycle after its byte is accepted
// throughput: one byte per cycle, set by the single registered pass through the step logic
// a waiting result holds s_tready low until m_tready is high, then bytes flow every cycle
// reset: walk returns to the tag header, mode and target frame id clear to zero
// ----------------------------------------------------------------------------
// id3v2_frame_reader
// walks an id3v2 tag byte by byte and streams out frame payload characters
// ----------------------------------------------------------------------------
module id3v2_frame_reader
    import id3r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tuser,    // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // char_value, frame_name
    output logic [2:0]  m_tuser,    // kind, char_valid
    output logic        m_tlast
);

    logic         mode_reg;
    logic [31:0]  target_reg;
    walk_state_t  state_reg;
    walk_state_t  state_next;
    logic         out_valid_reg;
    walk_result_t out_reg;
    logic         step_valid;
    walk_result_t step_res;
    logic         accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    id3r_step u_step
    (
        .cur             (state_reg),
        .data_byte       (s_tdata),
        .first_byte      (s_tuser),
        .mode            (mode_reg),
        .target_frame_id (target_reg),
        .nxt             (state_next),
        .res_valid       (step_valid),
        .res             (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_wdata[0];
                REG_TARGET: target_reg <= cfg_wdata;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WALK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step_valid)
            out_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_name, out_reg.char_value};
    assign m_tuser  = {out_reg.char_valid, out_reg.kind};
    assign m_tlast  = out_reg.finished;

    a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.header_count < HC_W'(HEADER_BYTES))
        else $error("header count out of range");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PAYLOAD |-> state_reg.payload_left != '0)
        else $error("payload phase with nothing left");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser && state_reg.phase == PH_DONE) |=> !m_tvalid)
        else $error("result after end of walk");

    a_char_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.kind == KIND_CHAR) |-> out_reg.char_valid)
        else $error("char result without char flag");

endmodule

### dv/id3r_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// id3r_scoreboard_pkg
// expected-result tracker for the id3v2 frame reader: a byte-level model of
// the tag walk that queues the predicted output of each accepted byte and
// compares the block's output requests against them in order
// ----------------------------------------------------------------------------
package id3r_scoreboard_pkg;
    import id3r_pkg::*;

    class walk_scoreboard;
        logic             mode_reg;
        logic [31:0]      target_reg;
        logic [1:0]       phase;
        logic [HC_W-1:0]  hdr_cnt;
        logic [LEN_W-1:0] tag_len;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] frm_len;
        logic [LEN_W-1:0] left;
        logic [31:0]      cur_id;
        logic             selected;
        logic             walk_mode;
        walk_result_t     expected_q[$];
        int               errors;
        int               byte_count;

        function new();
            mode_reg   = 1'b0;
            target_reg = '0;
            errors     = 0;
            byte_count = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_TAG;
            hdr_cnt   = '0;
            tag_len   = '0;
            pos       = '0;
            cur_id    = '0;
            frm_len   = '0;
            left      = '0;
            selected  = 1'b0;
            walk_mode = 1'b0;
        endfunction

        function void add_expected(logic [1:0] kind, logic cv, logic [7:0] ch,
                                   logic [31:0] name, logic fin);
            walk_result_t r;
            r.kind       = kind;
            r.char_valid = cv;
            r.char_value = cv ? ch : 8'h00;
            r.frame_name = name;
            r.finished   = fin;
            expected_q.push_back(r);
            if (fin)
                phase = PH_DONE;
        endfunction

        function void close_frame(logic cv, logic [7:0] ch);
            logic at_end;
            at_end  = (pos >= tag_len);
            phase   = PH_FRAME;
            hdr_cnt = '0;
            if (!walk_mode)
                add_expected((cur_id == ID_APIC) ? KIND_PICTURE : KIND_END,
                             cv, ch, cur_id, at_end);
            else if (selected)
                add_expected(KIND_END, cv, ch, cur_id, 1'b1);
            else if (at_end)
                add_expected(KIND_END, 1'b0, 8'h00, cur_id, 1'b1);
        endfunction

        function void note_byte(logic [7:0] b, logic first);
            logic [HC_W-1:0] n;
            logic            shown;
            if (first)
                restart();
            byte_count++;
            n = hdr_cnt;
            case (phase)
                PH_TAG:
                begin
                    if (n < 3)
                        cur_id = {8'h00, cur_id[15:0], b};
                    if (n >= HEADER_BYTES - 4)
                        tag_len = {tag_len[LEN_W-8:0], b[6:0]};
                    if (n < HEADER_BYTES - 1)
                    begin
                        hdr_cnt = n + 1'b1;
                        return;
                    end
                    hdr_cnt   = '0;
                    walk_mode = mode_reg;
                    if (cur_id != ID_TAG)
                    begin
                        add_expected(KIND_NO_TAG, 1'b0, 8'h00, 32'h0, 1'b1);
                        return;
                    end
                    cur_id = '0;
                    if (tag_len == '0)
                    begin
                        add_expected(KIND_END, 1'b0, 8'h00, 32'h0, 1'b1);
                        return;
                    end
                    phase = PH_FRAME;
                end
                PH_FRAME:
                begin
                    if (pos != LEN_MAX)
                        pos = pos + 1'b1;
                    // padding ends the walk
                    if (n == 0 && b == 8'h00)
                    begin
                        add_expected(KIND_END, 1'b0, 8'h00, 32'h0, 1'b1);
                        return;
                    end
                    if (n < 4)
                        cur_id = (n == 0) ? {24'h0, b} : {cur_id[23:0], b};
                    else if (n < 8)
                        frm_len = (n == 4) ? {{(LEN_W-7){1'b0}}, b[6:0]}
                                           : {frm_len[LEN_W-8:0], b[6:0]};
                    if (n < HEADER_BYTES - 1)
                    begin
                        hdr_cnt = n + 1'b1;
                        return;
                    end
                    hdr_cnt  = '0;
                    selected = walk_mode ? (cur_id == target_reg) : (cur_id != ID_APIC);
                    left     = frm_len;
                    if (left == '0)
                    begin
                        close_frame(1'b0, 8'h00);
                        return;
                    end
                    phase = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    shown = selected && b >= CHAR_LOW && b <= CHAR_HIGH;
                    if (pos != LEN_MAX)
                        pos = pos + 1'b1;
                    left = left - 1'b1;
                    if (left == '0)
                        close_frame(shown, b);
                    else if (shown)
                        add_expected(KIND_CHAR, 1'b1, b, cur_id, 1'b0);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(walk_result_t got);
            walk_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d frame_name %h", got.kind, got.frame_name);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.char_valid !== want.char_valid)
            begin
                $error("char_valid: expected %0d actual %0d", want.char_valid, got.char_valid);
                errors++;
            end
            if (got.char_value !== want.char_value)
            begin
                $error("char_value: expected %h actual %h", want.char_value, got.char_value);
                errors++;
            end
            if (got.frame_name !== want.frame_name)
            begin
                $error("frame_name: expected %h actual %h", want.frame_name, got.frame_name);
                errors++;
            end
            if (got.finished !== want.finished)
            begin
                $error("finished: expected %0d actual %0d", want.finished, got.finished);
                errors++;
            end
        endfunction
    endclass

endpackage

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives id3v2 files into the frame reader one byte per request: a few
// directed tags, then random well-formed tags with random frames, sizes and
// tag ends, mixed with broken headers, truncated files and noise; the output
// stream is checked against the scoreboard under random sender bursts and
// receiver stalls, with mode and target id changed between phases
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import id3r_pkg::*;
    import id3r_scoreboard_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          ITEM_COUNT     = 1700;
    localparam int          PHASE_BYTES    = 200;
    localparam logic [31:0] ID_TITLE       = "TIT2";
    localparam logic [31:0] ID_ARTIST      = "TPE1";
    localparam logic [31:0] ID_COMMENT     = "COMM";

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_MODE;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    walk_scoreboard sb = new();

    logic [8:0] file_q[$];
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         stall_style = 0;
    int         style_left = 0;
    int         cyc = 0;
    int         phase_idx;
    int         goal;
    logic       next_mode;
    logic [31:0] next_target;

    id3v2_frame_reader u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(32, 256);
        end
        style_left--;
        cyc++;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cyc % 5) < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result({m_tuser[1:0], m_tuser[2], m_tdata[7:0], m_tdata[39:8], m_tlast});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic void put(input logic first, input logic [7:0] b);
        file_q.push_back({first, b});
    endfunction

    // byte k of a syncsafe size, top bit randomly set
    function automatic logic [7:0] size_byte(input int unsigned v, input int k);
        logic [7:0] b;
        b    = 8'((v >> (7 * (3 - k))) & 32'h7F);
        b[7] = ($urandom_range(0, 3) == 0);
        return b;
    endfunction

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 8'($urandom_range(20, 126));
        if (r == 6)
        begin
            case ($urandom_range(0, 5))
                0:       return 8'd19;
                1:       return 8'd20;
                2:       return 8'd126;
                3:       return 8'd127;
                4:       return 8'd0;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 80)
            return $urandom_range(1, 12);
        if (r < 97)
            return $urandom_range(13, 40);
        return 32'(LEN_MAX);
    endfunction

    function automatic logic [31:0] pick_id();
        logic [31:0] id;
        case ($urandom_range(0, 9))
            0:       id = ID_TITLE;
            1:       id = ID_ARTIST;
            2:       id = ID_COMMENT;
            3:       id = ID_APIC;
            4, 5:    id = sb.target_reg;
            6, 7:    id = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                           8'($urandom_range(65, 90)), 8'($urandom_range(48, 57))};
            8:       id = $urandom;
            default: id = {8'($urandom_range(1, 255)), 24'($urandom)};
        endcase
        return id;
    endfunction

    function automatic void build_tag();
        int unsigned n_frames;
        int unsigned len;
        int unsigned cnt;
        int unsigned body;
        int unsigned size_field;
        int unsigned pad;
        int          base;
        int          i;
        int          k;
        logic [31:0] id;
        base = file_q.size();
        body = 0;
        put(1'b1, 8'h49);
        put(1'b0, 8'h44);
        put(1'b0, 8'h33);
        put(1'b0, 8'($urandom_range(2, 4)));
        put(1'b0, 8'($urandom_range(0, 255)));
        put(1'b0, 8'($urandom_range(0, 255)));
        for (k = 0; k < 4; k++)
            put(1'b0, 8'h00);
        n_frames = $urandom_range(1, 5);
        for (i = 0; i < n_frames; i++)
        begin
            id  = pick_id();
            len = pick_len();
            put(1'b0, id[31:24]);
            put(1'b0, id[23:16]);
            put(1'b0, id[15:8]);
            put(1'b0, id[7:0]);
            for (k = 0; k < 4; k++)
                put(1'b0, size_byte(len, k));
            put(1'b0, 8'($urandom_range(0, 255)));
            put(1'b0, 8'($urandom_range(0, 255)));
            cnt = (len > 40) ? $urandom_range(0, 40) : len;
            for (k = 0; k < cnt; k++)
                put(1'b0, pick_payload());
            body = body + 10 + len;
        end
        case ($urandom_range(0, 5))
            0, 1:    size_field = body;
            2:       size_field = $urandom_range(1, body);
            3:
            begin
                pad        = $urandom_range(1, 6);
                size_field = body + pad;
                for (k = 0; k < pad; k++)
                    put(1'b0, 8'h00);
            end
            4:       size_field = body + $urandom_range(1, 30);
            default: size_field = 32'(LEN_MAX);
        endcase
        if (size_field > LEN_MAX)
            size_field = 32'(LEN_MAX);
        for (k = 0; k < 4; k++)
            file_q[base + 6 + k] = {1'b0, size_byte(size_field, k)};
        cnt = $urandom_range(0, 3);
        for (k = 0; k < cnt; k++)
            put(1'b0, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_broken();
        int cnt;
        int k;
        case ($urandom_range(0, 4))
            // header without the tag mark
            0:
            begin
                put(1'b1, $urandom_range(0, 1) ? 8'h49 : 8'($urandom_range(0, 255)));
                put(1'b0, $urandom_range(0, 1) ? 8'h44 : 8'($urandom_range(0, 255)));
                put(1'b0, 8'($urandom_range(0, 255)));
                for (k = 0; k < 7; k++)
                    put(1'b0, 8'($urandom_range(0, 255)));
            end
            // header cut short by the next file
            1:
            begin
                put(1'b1, 8'h49);
                put(1'b0, 8'h44);
                put(1'b0, 8'h33);
                cnt = $urandom_range(0, 6);
                for (k = 0; k < cnt; k++)
                    put(1'b0, 8'($urandom_range(0, 255)));
            end
            // empty tag
            2:
            begin
                put(1'b1, 8'h49);
                put(1'b0, 8'h44);
                put(1'b0, 8'h33);
                for (k = 0; k < 3; k++)
                    put(1'b0, 8'($urandom_range(0, 255)));
                for (k = 0; k < 4; k++)
                    put(1'b0, {1'($urandom_range(0, 1)), 7'h00});
            end
            // noise with restarts anywhere
            3:
            begin
                put(1'b1, 8'($urandom_range(0, 255)));
                cnt = $urandom_range(5, 20);
                for (k = 0; k < cnt; k++)
                    put($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
            end
            // largest tag size, walk on random bytes
            default:
            begin
                put(1'b1, 8'h49);
                put(1'b0, 8'h44);
                put(1'b0, 8'h33);
                for (k = 0; k < 3; k++)
                    put(1'b0, 8'($urandom_range(0, 255)));
                for (k = 0; k < 4; k++)
                    put(1'b0, 8'hFF);
                cnt = $urandom_range(0, 20);
                for (k = 0; k < cnt; k++)
                    put(1'b0, 8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    // one request per byte, sender idles between bursts
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 300);
            else
            begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 30);
            end
        end
        s_tdata  <= b;
        s_tuser  <= first;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic play_file();
        int i;
        for (i = 0; i < file_q.size(); i++)
            send_byte(file_q[i][7:0], file_q[i][8]);
        file_q.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic apply_config(input logic m, input logic [31:0] target);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_wdata <= ($urandom & 32'hFFFF_FFFE) | {31'h0, m};
        @(negedge clk);
        cfg_index <= REG_TARGET;
        cfg_wdata <= target;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.mode_reg   = m;
        sb.target_reg = target;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        apply_config(1'b0, 32'h0);

        // empty tag with top bits set in the size
        put(1'b1, 8'h49);
        put(1'b0, 8'h44);
        put(1'b0, 8'h33);
        put(1'b0, 8'h04);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h80);
        put(1'b0, 8'h80);
        put(1'b0, 8'h80);
        put(1'b0, 8'h80);
        // one-byte frame ending the tag, lowest printable char
        put(1'b1, 8'h49);
        put(1'b0, 8'h44);
        put(1'b0, 8'h33);
        put(1'b0, 8'h03);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h0B);
        put(1'b0, ID_TITLE[31:24]);
        put(1'b0, ID_TITLE[23:16]);
        put(1'b0, ID_TITLE[15:8]);
        put(1'b0, ID_TITLE[7:0]);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h01);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, CHAR_LOW);
        play_file();
        drain();

        phase_idx = 1;
        while (sb.byte_count < ITEM_COUNT)
        begin
            case (phase_idx)
                1:
                begin
                    next_mode   = 1'b1;
                    next_target = ID_TITLE;
                end
                2:
                begin
                    next_mode   = 1'b0;
                    next_target = 32'hFFFF_FFFF;
                end
                3:
                begin
                    next_mode   = 1'b1;
                    next_target = ID_APIC;
                end
                4:
                begin
                    next_mode   = 1'b1;
                    next_target = 32'hFFFF_FFFF;
                end
                5:
                begin
                    next_mode   = 1'b1;
                    next_target = 32'h0;
                end
                default:
                begin
                    next_mode   = 1'($urandom_range(0, 1));
                    next_target = $urandom_range(0, 1) ? ID_ARTIST : $urandom;
                end
            endcase
            apply_config(next_mode, next_target);
            goal = sb.byte_count + PHASE_BYTES;
            while (sb.byte_count < goal && sb.byte_count < ITEM_COUNT)
            begin
                if ($urandom_range(0, 4) == 0)
                    build_broken();
                else
                    build_tag();
                play_file();
            end
            drain();
            phase_idx++;
        end

        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0 && !m_tvalid)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
